// ===== rtl/tcgr_pkg.sv =====
package tcgr_pkg;

  // cell geometry
  localparam int unsigned GlyphWidth  = 8;
  localparam int unsigned GlyphHeight = 8;
  localparam int unsigned GlyphRows   = 7;

  // control characters
  localparam logic [7:0] CharLf = 8'd10;
  localparam logic [7:0] CharCr = 8'd13;

  // register indexes on the apb port
  localparam logic [1:0] RegEnabled = 2'd0;
  localparam logic [1:0] RegWidth   = 2'd1;
  localparam logic [1:0] RegHeight  = 2'd2;
  localparam logic [1:0] RegPitch   = 2'd3;

  // configuration seen by the datapath
  typedef struct packed {
    logic        enabled;
    logic [12:0] width;
    logic [12:0] height;
    logic [13:0] pitch;
  } cfg_t;

  // one character job handed to the raster walker
  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] fg;
    logic [12:0] x0;
    logic [3:0]  nx;
    logic [3:0]  ny;
    logic [26:0] row_base;
  } job_t;

  // upper-case letters, leave the rest
  function automatic logic [7:0] to_upper(input logic [7:0] code);
    logic [7:0] res;
    res = code;
    if (code >= 8'h61 && code <= 8'h7a) begin
      res = code - 8'h20;
    end
    return res;
  endfunction

  // 5x7 font, row 0 in the top bits; unknown codes give '?'
  function automatic logic [34:0] glyph_rows(input logic [7:0] code);
    logic [34:0] r;
    unique case (to_upper(code))
      8'h41: r = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h42: r = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
      8'h43: r = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
      8'h44: r = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
      8'h45: r = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
      8'h46: r = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
      8'h47: r = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
      8'h48: r = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h49: r = {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h4a: r = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
      8'h4b: r = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      8'h4c: r = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
      8'h4d: r = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4e: r = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4f: r = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h50: r = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
      8'h51: r = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
      8'h52: r = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
      8'h53: r = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
      8'h54: r = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: r = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h56: r = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
      8'h57: r = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
      8'h58: r = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
      8'h59: r = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5a: r = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
      8'h30: r = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
      8'h31: r = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h32: r = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
      8'h33: r = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
      8'h34: r = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
      8'h35: r = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
      8'h36: r = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
      8'h37: r = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: r = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
      8'h39: r = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
      8'h5b: r = {5'h0e, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0e};
      8'h5d: r = {5'h0e, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0e};
      8'h28: r = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
      8'h29: r = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
      8'h3a: r = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      8'h2f: r = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
      8'h2d: r = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
      8'h3d: r = {5'h00, 5'h00, 5'h1f, 5'h00, 5'h1f, 5'h00, 5'h00};
      8'h2e: r = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c};
      8'h2c: r = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h04, 5'h08};
      8'h3b: r = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h08};
      8'h5f: r = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1f};
      8'h20: r = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      default: r = {5'h1f, 5'h11, 5'h02, 5'h04, 5'h04, 5'h00, 5'h04};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tcgr_font_rom.sv =====
module tcgr_font_rom import tcgr_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] code_i,
  input  logic [2:0] row_i,
  output logic [4:0] row_bits_o
);

  logic [34:0] rows;
  logic [4:0]  row_bits_d;
  logic [4:0]  row_bits_q;

  // pick one glyph row, the bottom cell row is blank
  always_comb begin
    rows = glyph_rows(code_i);
    unique case (row_i)
      3'd0:    row_bits_d = rows[34:30];
      3'd1:    row_bits_d = rows[29:25];
      3'd2:    row_bits_d = rows[24:20];
      3'd3:    row_bits_d = rows[19:15];
      3'd4:    row_bits_d = rows[14:10];
      3'd5:    row_bits_d = rows[9:5];
      3'd6:    row_bits_d = rows[4:0];
      default: row_bits_d = 5'd0;
    endcase
  end

  // synchronous read port, holds while the pipe stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_bits_q <= row_bits_d;
    end
  end

  assign row_bits_o = row_bits_q;

endmodule

// ===== rtl/tcgr_regs.sv =====
module tcgr_regs import tcgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegEnabled: cfg_q.enabled <= pwdata[0];
        RegWidth:   cfg_q.width   <= pwdata[12:0];
        RegHeight:  cfg_q.height  <= pwdata[12:0];
        RegPitch:   cfg_q.pitch   <= pwdata[13:0];
        default:    cfg_q         <= cfg_q;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      RegEnabled: prdata = {31'd0, cfg_q.enabled};
      RegWidth:   prdata = {19'd0, cfg_q.width};
      RegHeight:  prdata = {19'd0, cfg_q.height};
      RegPitch:   prdata = {18'd0, cfg_q.pitch};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tcgr_raster.sv =====
module tcgr_raster import tcgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [13:0] pitch_i,
  input  logic        start_i,
  input  job_t        job_i,
  output logic        slot_free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [26:0] pixel_offset_o,
  output logic [31:0] pixel_value_o,
  output logic        last_pixel_o
);

  // walker state
  logic        active_q, active_d;
  job_t        job_q;
  logic [2:0]  gx_q, gx_d;
  logic [2:0]  gy_q, gy_d;
  logic [26:0] base_q, base_d;

  // stage one: waits for the font row
  logic        s1_valid_q;
  logic [26:0] s1_offset_q;
  logic [2:0]  s1_gx_q;
  logic [31:0] s1_fg_q;
  logic        s1_last_q;

  // output register
  logic        out_valid_q;
  logic [26:0] out_offset_q;
  logic [31:0] out_value_q;
  logic        out_last_q;

  logic        adv;
  logic        row_end;
  logic        walk_last;
  logic [26:0] pix_offset;
  logic [4:0]  row_bits;
  logic        pix_on;

  assign adv       = !out_valid_q || out_ready_i;
  assign row_end   = ({1'b0, gx_q} == job_q.nx - 4'd1);
  assign walk_last = row_end && ({1'b0, gy_q} == job_q.ny - 4'd1);
  assign pix_offset = base_q + {14'd0, job_q.x0} + {24'd0, gx_q};

  assign slot_free_o = !active_q || (adv && walk_last);

  tcgr_font_rom u_font_rom (
    .clk_i      (clk_i),
    .en_i       (adv),
    .code_i     (job_q.code),
    .row_i      (gy_q),
    .row_bits_o (row_bits)
  );

  // walk the visible part of the cell, row by row
  always_comb begin
    active_d = active_q;
    gx_d     = gx_q;
    gy_d     = gy_q;
    base_d   = base_q;
    if (start_i) begin
      active_d = 1'b1;
      gx_d     = '0;
      gy_d     = '0;
      base_d   = job_i.row_base;
    end else if (active_q && adv) begin
      if (walk_last) begin
        active_d = 1'b0;
      end else if (row_end) begin
        gx_d   = '0;
        gy_d   = gy_q + 3'd1;
        base_d = base_q + {13'd0, pitch_i};
      end else begin
        gx_d = gx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      if (adv) begin
        s1_valid_q  <= active_q;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    gx_q   <= gx_d;
    gy_q   <= gy_d;
    base_q <= base_d;
    if (start_i) begin
      job_q <= job_i;
    end
    if (adv) begin
      s1_offset_q  <= pix_offset;
      s1_gx_q      <= gx_q;
      s1_fg_q      <= job_q.fg;
      s1_last_q    <= walk_last;
      out_offset_q <= s1_offset_q;
      out_value_q  <= pix_on ? s1_fg_q : 32'd0;
      out_last_q   <= s1_last_q;
    end
  end

  // glyph sits in cell columns one to five
  always_comb begin
    unique case (s1_gx_q)
      3'd1:    pix_on = row_bits[4];
      3'd2:    pix_on = row_bits[3];
      3'd3:    pix_on = row_bits[2];
      3'd4:    pix_on = row_bits[1];
      3'd5:    pix_on = row_bits[0];
      default: pix_on = 1'b0;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_offset_o = out_offset_q;
  assign pixel_value_o  = out_value_q;
  assign last_pixel_o   = out_last_q;

  // a new job only lands in a free slot
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> slot_free_o)
    else $error("job started while walker busy");

  // a started job is walking next cycle
  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> active_q)
    else $error("job lost after start");

  // walker stays inside the visible window
  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ({1'b0, gx_q} < job_q.nx) && ({1'b0, gy_q} < job_q.ny))
    else $error("walker out of cell window");

  // the final pixel of a job shows up in stage one as last
  a_last_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && adv && walk_last) |=> (s1_valid_q && s1_last_q))
    else $error("last pixel mark lost");

endmodule

// ===== rtl/text_console_glyph_renderer.sv =====
// Text console glyph renderer: draws one character per input item as an
// 8x8 cell of 32-bit pixels at a text cursor and advances the cursor.
// Input channel (in_valid_i/in_ready_o): char_code_i and fg_color_i.
// Output channel (out_valid_o/out_ready_i): one pixel write per item,
// pixel_offset_o = y*pitch+x, pixel_value_o, last_pixel_o on the final one.
// Configuration goes through the apb port: enabled, screen width, screen
// height and line pitch at byte addresses 0, 4, 8 and 12.
// A drawn character gives one pixel per cycle while the receiver does not
// stall, for the part of its cell that lies on screen, nx*ny pixels, at most
// 64. The raster walker sets that rate; the next character is taken in the
// cycle the walker issues the last pixel of the current one. Line feed,
// carriage return, disabled and fully off-screen characters are taken and
// give nothing. The first pixel goes from the walker registers through
// stage one, with the registered font rom read, to the output register.
// Reset clears the registers, the cursor and the pipeline valid bits.
// When the receiver stalls the whole pixel pipeline holds and the output
// register keeps its item; new input items wait once the walker is busy.
module text_console_glyph_renderer import tcgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic [31:0] fg_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [26:0] pixel_offset_o,
  output logic [31:0] pixel_value_o,
  output logic        last_pixel_o
);

  cfg_t        cfg;
  logic        slot_free;
  logic        accept;
  logic        is_lf;
  logic        is_cr;
  logic        start;
  job_t        job;

  logic [9:0]  col_q, col_d;
  logic [9:0]  row_q, row_d;
  logic [9:0]  row_inc;
  logic [10:0] col_inc;
  logic [12:0] x0;
  logic [12:0] y0;
  logic [12:0] x_room;
  logic [12:0] y_room;
  logic [3:0]  nx;
  logic [3:0]  ny;

  tcgr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = slot_free;
  assign accept     = in_valid_i && slot_free;
  assign is_lf      = (char_code_i == CharLf);
  assign is_cr      = (char_code_i == CharCr);

  // visible part of the cell at the cursor
  always_comb begin
    x0     = {col_q, 3'b000};
    y0     = {row_q, 3'b000};
    x_room = cfg.width - x0;
    y_room = cfg.height - y0;
    if (cfg.width <= x0) begin
      nx = 4'd0;
    end else if (x_room >= 13'd8) begin
      nx = 4'd8;
    end else begin
      nx = x_room[3:0];
    end
    if (cfg.height <= y0) begin
      ny = 4'd0;
    end else if (y_room >= 13'd8) begin
      ny = 4'd8;
    end else begin
      ny = y_room[3:0];
    end
  end

  assign start = accept && cfg.enabled && !is_lf && !is_cr && (nx != 4'd0) && (ny != 4'd0);

  // job for the walker, the row base product is registered in the walker
  always_comb begin
    job.code     = char_code_i;
    job.fg       = fg_color_i;
    job.x0       = x0;
    job.nx       = nx;
    job.ny       = ny;
    job.row_base = 27'(y0 * cfg.pitch);
  end

  // cursor update, rows wrap at the bottom with no scrolling
  always_comb begin
    row_inc = row_q + 10'd1;
    if (row_inc >= cfg.height[12:3]) begin
      row_inc = '0;
    end
    col_inc = {1'b0, col_q} + 11'd1;
    col_d   = col_q;
    row_d   = row_q;
    if (accept && cfg.enabled) begin
      priority if (is_lf) begin
        col_d = '0;
        row_d = row_inc;
      end else if (is_cr) begin
        col_d = '0;
      end else if ((col_inc + 11'd1) >= {1'b0, cfg.width[12:3]}) begin
        col_d = '0;
        row_d = row_inc;
      end else begin
        col_d = col_inc[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  tcgr_raster u_raster (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pitch_i        (cfg.pitch),
    .start_i        (start),
    .job_i          (job),
    .slot_free_o    (slot_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_offset_o (pixel_offset_o),
    .pixel_value_o  (pixel_value_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

// ===== sim/tb_text_console_glyph_renderer.sv =====
`timescale 1ns / 1ps

module tb_text_console_glyph_renderer import tcgr_pkg::*;;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 8;

  // font: code byte, then rows 0..6 of the 5-bit glyph, one byte each
  localparam logic [49*64-1:0] FontRom = {
    64'h41_0e_11_11_1f_11_11_11, 64'h42_1e_11_11_1e_11_11_1e,
    64'h43_0e_11_10_10_10_11_0e, 64'h44_1e_11_11_11_11_11_1e,
    64'h45_1f_10_10_1e_10_10_1f, 64'h46_1f_10_10_1e_10_10_10,
    64'h47_0e_11_10_17_11_11_0f, 64'h48_11_11_11_1f_11_11_11,
    64'h49_0e_04_04_04_04_04_0e, 64'h4a_07_02_02_02_12_12_0c,
    64'h4b_11_12_14_18_14_12_11, 64'h4c_10_10_10_10_10_10_1f,
    64'h4d_11_1b_15_15_11_11_11, 64'h4e_11_19_15_13_11_11_11,
    64'h4f_0e_11_11_11_11_11_0e, 64'h50_1e_11_11_1e_10_10_10,
    64'h51_0e_11_11_11_15_12_0d, 64'h52_1e_11_11_1e_14_12_11,
    64'h53_0f_10_10_0e_01_01_1e, 64'h54_1f_04_04_04_04_04_04,
    64'h55_11_11_11_11_11_11_0e, 64'h56_11_11_11_11_11_0a_04,
    64'h57_11_11_11_15_15_15_0a, 64'h58_11_11_0a_04_0a_11_11,
    64'h59_11_11_0a_04_04_04_04, 64'h5a_1f_01_02_04_08_10_1f,
    64'h30_0e_11_13_15_19_11_0e, 64'h31_04_0c_04_04_04_04_0e,
    64'h32_0e_11_01_02_04_08_1f, 64'h33_1e_01_01_0e_01_01_1e,
    64'h34_02_06_0a_12_1f_02_02, 64'h35_1f_10_10_1e_01_01_1e,
    64'h36_0e_10_10_1e_11_11_0e, 64'h37_1f_01_02_04_08_08_08,
    64'h38_0e_11_11_0e_11_11_0e, 64'h39_0e_11_11_0f_01_01_0e,
    64'h5b_0e_08_08_08_08_08_0e, 64'h5d_0e_02_02_02_02_02_0e,
    64'h28_02_04_08_08_08_04_02, 64'h29_08_04_02_02_02_04_08,
    64'h3a_00_04_04_00_04_04_00, 64'h2f_01_01_02_04_08_10_10,
    64'h2d_00_00_00_1f_00_00_00, 64'h3d_00_00_1f_00_1f_00_00,
    64'h2e_00_00_00_00_00_0c_0c, 64'h2c_00_00_00_00_0c_04_08,
    64'h3b_00_04_04_00_04_04_08, 64'h5f_00_00_00_00_00_00_1f,
    64'h20_00_00_00_00_00_00_00
  };
  localparam logic [55:0] UnknownGlyph = 56'h1f_11_02_04_04_00_04;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] fg;
  } char_item_t;

  typedef struct packed {
    logic [26:0] offset;
    logic [31:0] value;
    logic        last;
  } pixel_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // apb side
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // character and pixel channels
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code  = '0;
  logic [31:0] fg_color   = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [26:0] pixel_offset;
  logic [31:0] pixel_value;
  logic        last_pixel;

  // console shadow: registers and cursor
  cfg_t        console_cfg = '0;
  logic [9:0]  cursor_col  = '0;
  logic [9:0]  cursor_row  = '0;
  logic [55:0] glyph_tbl [256];

  char_item_t  char_queue[$];
  pixel_t      pending_pixels[$];
  char_item_t  head_item;
  pixel_t      want_pix;

  int   idle_stage   = 0;
  int   error_count  = 0;
  int   pixels_seen  = 0;
  int   quiet_cycles = 0;
  int   hold_left    = 0;
  logic hold_req     = 1'b0;
  logic hold_done    = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  text_console_glyph_renderer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .fg_color_i     (fg_color),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_offset_o (pixel_offset),
    .pixel_value_o  (pixel_value),
    .last_pixel_o   (last_pixel)
  );

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // new line: column home, row down, back to the top past the last text row
  task automatic feed_line();
    cursor_col = '0;
    cursor_row = cursor_row + 10'd1;
    if (int'(cursor_row) >= int'(console_cfg.height / GlyphHeight)) begin
      cursor_row = '0;
    end
  endtask

  // expected pixel writes for one character, then the cursor update
  task automatic predict_char(input logic [7:0] code, input logic [31:0] fg);
    logic [55:0]     rows;
    logic [7:0]      bits;
    int unsigned     x0, y0, nx, ny, gx, gy;
    longint unsigned off;
    pixel_t          pix;
    if (console_cfg.enabled) begin
      if (code == CharLf) begin
        feed_line();
      end else if (code == CharCr) begin
        cursor_col = '0;
      end else begin
        rows = glyph_tbl[code];
        x0 = cursor_col * GlyphWidth;
        y0 = cursor_row * GlyphHeight;
        // visible part of the cell is a rectangle clipped at the screen edges
        nx = (console_cfg.width > x0) ? console_cfg.width - x0 : 0;
        ny = (console_cfg.height > y0) ? console_cfg.height - y0 : 0;
        if (nx > GlyphWidth) nx = GlyphWidth;
        if (ny > GlyphHeight) ny = GlyphHeight;
        for (gy = 0; gy < ny; gy++) begin
          bits = (gy < GlyphRows) ? rows[55 - 8*gy -: 8] << 2 : 8'h00;
          for (gx = 0; gx < nx; gx++) begin
            off = y0 + gy;
            off = off * console_cfg.pitch + x0 + gx;
            pix.offset = off[26:0];
            pix.value  = bits[7 - gx] ? fg : 32'h0;
            pix.last   = (gy == ny - 1) && (gx == nx - 1);
            pending_pixels.push_back(pix);
          end
        end
        cursor_col = cursor_col + 10'd1;
        if (int'(cursor_col) + 1 >= int'(console_cfg.width / GlyphWidth)) begin
          feed_line();
        end
      end
    end
  endtask

  function automatic int send_gap_pct();
    case (idle_stage)
      0: return 10;
      1: return 47;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_gap_pct();
    case (idle_stage)
      0: return 47;
      1: return 10;
      default: return 0;
    endcase
  endfunction

  // character driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_char(char_code, fg_color);
      end
      if (!in_valid || in_ready) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
          head_item = char_queue.pop_front();
          in_valid  <= 1'b1;
          char_code <= head_item.code;
          fg_color  <= head_item.fg;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel receiver ready, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct());
    end
  end

  // pixel monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel offset %0h value %0h last %0b",
                             pixel_offset, pixel_value, last_pixel));
      end else begin
        want_pix = pending_pixels.pop_front();
        if (pixel_offset !== want_pix.offset) begin
          flag_error($sformatf("pixel %0d offset %0h, want %0h",
                               pixels_seen, pixel_offset, want_pix.offset));
        end
        if (pixel_value !== want_pix.value) begin
          flag_error($sformatf("pixel %0d value %0h, want %0h",
                               pixels_seen, pixel_value, want_pix.value));
        end
        if (last_pixel !== want_pix.last) begin
          flag_error($sformatf("pixel %0d last %0b, want %0b",
                               pixels_seen, last_pixel, want_pix.last));
        end
      end
      pixels_seen++;
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("timeout: no item moved for %0d cycles", WatchdogLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegEnabled: console_cfg.enabled = val[0];
      RegWidth:   console_cfg.width   = val[12:0];
      RegHeight:  console_cfg.height  = val[12:0];
      RegPitch:   console_cfg.pitch   = val[13:0];
      default: ;
    endcase
  endtask

  task automatic program_screen(input logic en, input logic [12:0] w,
                                input logic [12:0] h, input logic [13:0] p);
    apb_write(RegEnabled, {31'b0, en});
    apb_write(RegWidth, {19'b0, w});
    apb_write(RegHeight, {19'b0, h});
    apb_write(RegPitch, {18'b0, p});
  endtask

  task automatic queue_char(input logic [7:0] code, input logic [31:0] fg);
    char_item_t item;
    item.code = code;
    item.fg   = fg;
    char_queue.push_back(item);
  endtask

  // everything sent and drawn, then a drain wait for zero-pixel items
  task automatic wait_idle();
    do @(negedge clk_i);
    while (char_queue.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly text from the font, some control bytes, some arbitrary bytes
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 60) return FontRom[$urandom_range(48)*64 + 56 +: 8];
    if (r < 70) return 8'h61 + 8'($urandom_range(25));
    if (r < 78) return CharLf;
    if (r < 84) return CharCr;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] pick_color();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  initial begin : stimulus
    int          i, batch, k, mode;
    logic [7:0]  c;
    logic        en;
    logic [12:0] w, h;
    logic [13:0] p;

    // glyph lookup by byte, lower-case letters share the upper-case rows
    for (i = 0; i < 256; i++) glyph_tbl[i] = UnknownGlyph;
    for (i = 0; i < 49; i++) begin
      c = FontRom[i*64 + 56 +: 8];
      glyph_tbl[c] = FontRom[i*64 +: 56];
      if (c >= 8'h41 && c <= 8'h5a) glyph_tbl[c + 8'h20] = FontRom[i*64 +: 56];
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers still at reset: console disabled, nothing drawn
    queue_char("A", 32'hFFFF_FFFF);
    queue_char(CharLf, 32'h0);
    queue_char(8'hFF, $urandom);
    wait_idle();

    // 10x5 text screen, receiver stalls long while characters keep coming
    program_screen(1'b1, 13'd80, 13'd40, 14'd100);
    hold_req = 1'b1;
    queue_char("A", 32'hFFFF_FFFF);
    queue_char("a", 32'h0);
    queue_char("z", $urandom);
    queue_char("0", $urandom);
    queue_char("9", $urandom);
    queue_char("?", $urandom);
    queue_char(8'h7F, $urandom);
    queue_char(8'h80, $urandom);
    queue_char(8'hFF, $urandom);
    // right edge reached, next line
    queue_char(8'h00, $urandom);
    queue_char(" ", $urandom);
    queue_char(CharCr, $urandom);
    queue_char("[", $urandom);
    queue_char("_", $urandom);
    queue_char(CharLf, $urandom);
    queue_char(CharLf, $urandom);
    queue_char(CharLf, $urandom);
    queue_char(";", $urandom);
    // bottom reached, back to the top row
    queue_char(CharLf, $urandom);
    queue_char(")", $urandom);
    wait_idle();

    // screen smaller than a cell: cursor starts off screen, then partial cells
    program_screen(1'b1, 13'd5, 13'd3, 14'd7);
    queue_char("W", $urandom);
    queue_char("W", $urandom);
    queue_char("H", $urandom);
    wait_idle();
    program_screen(1'b1, 13'd0, 13'd0, 14'd0);
    queue_char("X", $urandom);
    queue_char(CharLf, $urandom);
    wait_idle();

    // largest screen and widest pitch, a few text rows down
    program_screen(1'b1, 13'd8191, 13'd8191, 14'd16383);
    for (i = 0; i < 4; i++) queue_char(CharLf, $urandom);
    queue_char("B", $urandom);
    queue_char("m", $urandom);
    queue_char(CharLf, $urandom);
    wait_idle();

    // random text under random screens
    for (batch = 0; batch < 9; batch++) begin
      idle_stage = batch / 3;
      mode = $urandom_range(9);
      en = 1'b1;
      case (mode)
        0: begin
          en = 1'b0;
          w  = 13'($urandom_range(8191));
          h  = 13'($urandom_range(8191));
          p  = 14'($urandom_range(16383));
        end
        1: begin
          w = 13'($urandom_range(15));
          h = 13'($urandom_range(15));
          p = 14'($urandom_range(31));
        end
        2: begin
          w = 13'd8191;
          h = 13'($urandom_range(8191, 8));
          p = $urandom_range(1) ? 14'd16383 : 14'd0;
        end
        default: begin
          w = 13'($urandom_range(160, 8));
          h = 13'($urandom_range(80, 8));
          p = 14'(w) + 14'($urandom_range(64));
        end
      endcase
      program_screen(en, w, h, p);
      for (k = 0; k < 9; k++) queue_char(pick_code(), pick_color());
      wait_idle();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tcgr_pkg.sv
rtl/tcgr_font_rom.sv
rtl/tcgr_regs.sv
rtl/tcgr_raster.sv
rtl/text_console_glyph_renderer.sv
sim/tb_text_console_glyph_renderer.sv
